// ===== src/fnpll_pkg.sv =====
// ----------------------------------------------------------------------------
// Fractional-N PLL register calculator package
// Shared types, codes and constants.
// ----------------------------------------------------------------------------
package fnpll_pkg;

  localparam int unsigned FreqMax = 4400000;
  localparam int unsigned FreqMin = 35;

  localparam logic [1:0] CFG_R2 = 2'd0;
  localparam logic [1:0] CFG_R3 = 2'd1;
  localparam logic [1:0] CFG_R5 = 2'd2;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;      // capture command and start the divider
    logic div_step;  // one step of the reciprocal divider for n_int and frac
    logic gcd_step;  // one subtract step of the gcd
    logic finish;    // reduce frac and modulus
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic gcd_done;
    logic red_done;
  } dp_status_t;

endpackage

// ===== src/fnpll_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface fnpll_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/fnpll_dp.sv =====
// ----------------------------------------------------------------------------
// Register calculator datapath
// Clamps the frequency, finds the divider exponent, divides by the PFD step
// with reciprocal multiplication and reduces the fraction by a subtractive gcd.
// ----------------------------------------------------------------------------
module fnpll_dp import fnpll_pkg::*; #(
  parameter int unsigned PFD_MHZ = 25,
  parameter int unsigned MODULUS = 25000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [22:0] freq_i,
  output dp_status_t  status_o,
  output logic [4:0]  exp_o,
  output logic [31:0] nint_o,
  output logic [31:0] frac_o,
  output logic [31:0] mod_o
);

  localparam int unsigned StepKhz = PFD_MHZ * 1000;
  // Reciprocals of the two constant divisors. Each product estimate is low by
  // at most one, so a single compare and subtract finishes the quotient.
  localparam logic [24:0] RecipStep  = 25'((64'd1 << 32) / 64'(StepKhz));
  localparam logic [24:0] RecipStep2 = 25'((64'd1 << 34) / 64'(2 * StepKhz));
  localparam logic [16:0] StepW  = 17'(StepKhz);
  localparam logic [17:0] Step2W = 18'(2 * StepKhz);
  localparam logic [16:0] Mod2W  = 17'(2 * MODULUS);
  localparam logic [16:0] ModW   = 17'(MODULUS);

  logic [4:0]  exp_q, exp_d;
  logic [23:0] v_q, v_d;
  logic [16:0] nint_q, nint_d;
  logic [17:0] rem_q, rem_d;
  logic [33:0] num_q, num_d;
  logic [16:0] frac_q, frac_d;
  logic [18:0] rb_q, rb_d;
  logic [2:0]  dst_q, dst_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [16:0] ga_q, ga_d, gb_q, gb_d;
  logic [16:0] q_q, q_d;       // reduction quotient counter state
  logic [16:0] fr_q, fr_d, md_q, md_d;
  logic [1:0]  ph_q, ph_d;

  logic [22:0] fc;
  logic [4:0]  ex;
  logic [48:0] prod_v;
  logic [33:0] nstep;
  logic [57:0] prod_n;
  logic [34:0] fstep;

  always_comb begin
    fc = freq_i;
    if (freq_i > 23'(FreqMax)) fc = 23'(FreqMax);
    if (freq_i < 23'(FreqMin)) fc = 23'(FreqMin);
    ex = 5'd1;
    for (int k = 1; k < 30; k++) begin
      if (k == int'(ex) && ({41'd0, fc} << (k + 1)) <= 64'(FreqMax)) ex = ex + 5'd1;
    end
  end

  assign prod_v = 49'(v_q) * 49'(RecipStep);
  assign nstep  = 34'(nint_q) * 34'(StepW);
  assign prod_n = 58'(num_q) * 58'(RecipStep2);
  assign fstep  = 35'(frac_q) * 35'(Step2W);

  always_comb begin
    exp_d = exp_q; v_d = v_q; nint_d = nint_q; rem_d = rem_q; num_d = num_q;
    frac_d = frac_q; rb_d = rb_q; dst_d = dst_q; cnt_d = cnt_q;
    ga_d = ga_q; gb_d = gb_q; q_d = q_q; fr_d = fr_q; md_d = md_q; ph_d = ph_q;
    if (cmd_i.load) begin
      exp_d = ex;
      v_d = {1'b0, fc} << ex;
      dst_d = 3'd0;
      ph_d = 2'd0;
    end else if (cmd_i.div_step && ph_q == 2'd0) begin
      dst_d = dst_q + 3'd1;
      unique case (dst_q)
        3'd0: nint_d = prod_v[48:32];
        3'd1: rem_d = 18'(34'(v_q) - nstep);
        3'd2: begin
          if (rem_q >= 18'(StepW)) begin
            nint_d = nint_q + 17'd1;
            rem_d = rem_q - 18'(StepW);
          end
        end
        // Rounded fraction: (2*rem*MOD + step) / (2*step).
        3'd3: num_d = 34'(rem_q) * 34'(Mod2W) + 34'(StepW);
        3'd4: frac_d = prod_n[50:34];
        3'd5: rb_d = 19'(35'(num_q) - fstep);
        default: begin
          if (rb_q >= 19'(Step2W)) frac_d = frac_q + 17'd1;
          dst_d = 3'd0;
          ph_d = 2'd1;
        end
      endcase
    end else if (cmd_i.gcd_step) begin
      if (ph_q == 2'd1) begin
        fr_d = frac_q;
        ga_d = ModW;
        gb_d = frac_q;
        ph_d = 2'd2;
      end else if (gb_q != 17'd0) begin
        if (ga_q >= gb_q) ga_d = ga_q - gb_q;
        else begin ga_d = gb_q; gb_d = ga_q; end
      end
    end else if (cmd_i.finish) begin
      if (ph_q == 2'd2) begin
        if (fr_q == 17'd0) ga_d = ModW;
        md_d = ModW;
        q_d = '0;
        ph_d = 2'd3;
        cnt_d = 2'd0;
      end else if (cnt_q == 2'd0) begin
        // divide fr by ga by repeated subtraction
        if (fr_q >= ga_q) begin fr_d = fr_q - ga_q; q_d = q_q + 17'd1; end
        else begin fr_d = q_q; q_d = '0; cnt_d = 2'd1; end
      end else if (cnt_q == 2'd1) begin
        if (md_q >= ga_q) begin md_d = md_q - ga_q; q_d = q_q + 17'd1; end
        else begin md_d = (q_q == 17'd1) ? 17'd2 : q_q; cnt_d = 2'd2; end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_q <= '0;
      cnt_q <= '0;
      ph_q <= '0;
    end else begin
      dst_q <= dst_d;
      cnt_q <= cnt_d;
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d; v_q <= v_d; nint_q <= nint_d; rem_q <= rem_d; num_q <= num_d;
    frac_q <= frac_d; rb_q <= rb_d;
    ga_q <= ga_d; gb_q <= gb_d; q_q <= q_d; fr_q <= fr_d; md_q <= md_d;
  end

  assign status_o.div_done = (ph_q == 2'd1);
  assign status_o.gcd_done = (ph_q == 2'd2) && (gb_q == 17'd0);
  assign status_o.red_done = (ph_q == 2'd3) && (cnt_q == 2'd2);
  assign exp_o  = exp_q;
  assign nint_o = {15'd0, nint_q};
  assign frac_o = {15'd0, fr_q};
  assign mod_o  = {15'd0, md_q};

endmodule

// ===== src/fnpll_ctrl.sv =====
// ----------------------------------------------------------------------------
// Register calculator controller
// Sequences the datapath and then emits the six register words.
// ----------------------------------------------------------------------------
module fnpll_ctrl import fnpll_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] word_idx_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_GCD  = 3'd2;
  localparam logic [2:0] S_RED  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) state_d = S_GCD;
      end
      S_GCD: begin
        cmd_o.gcd_step = 1'b1;
        if (status_i.gcd_done) state_d = S_RED;
      end
      S_RED: begin
        cmd_o.finish = 1'b1;
        if (status_i.red_done) begin
          state_d = S_OUT;
          idx_d = '0;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (idx_q == 3'd5) state_d = S_IDLE;
          idx_d = idx_q + 3'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign word_idx_o  = idx_q;

  word_idx_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q <= 3'd5) else $error("word index out of range");
  no_accept_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready while emitting");
  last_returns_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && idx_q == 3'd5) |=> in_ready_o)
    else $error("did not return to idle");

endmodule

// ===== src/frac_n_pll_register_calc.sv =====
// An accepted command runs the reciprocal divider, then the subtract and swap
// steps of the gcd loop, then the frac/gcd and MODULUS/gcd reduction, before the
// first word is emitted.
// Throughput: one command at a time; the six words leave one per cycle while
// the sink is ready, and the next command is taken the cycle after the last.
// Reset clears the controller and restores the three fixed register words.
// ----------------------------------------------------------------------------
// Fractional-N PLL register calculator
// Turns a tuning command into six synthesizer register words.
// ----------------------------------------------------------------------------
module frac_n_pll_register_calc import fnpll_pkg::*; #(
  parameter int unsigned PFD_MHZ = 25,
  parameter int unsigned MODULUS = 25000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fnpll_if.sink       in_ch,
  fnpll_if.source     out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] r2_q, r3_q, r5_q;
  logic        ch_q;
  logic [4:0]  att_q;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [4:0]  exp;
  logic [31:0] nint, frac, modv, word;
  logic [2:0]  idx;
  logic        in_ready, out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q <= 32'h4E42;
      r3_q <= 32'h4B3;
      r5_q <= 32'h580005;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_R2: r2_q <= cfg_data_i;
        CFG_R3: r3_q <= cfg_data_i;
        CFG_R5: r5_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ready) begin
      ch_q <= in_ch.data[28];
      att_q <= in_ch.data[4:0];
    end
  end

  fnpll_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ready),
    .status_i(status), .cmd_o(cmd),
    .out_valid_o(out_valid), .out_ready_i(out_ch.ready),
    .word_idx_o(idx)
  );

  fnpll_dp #(.PFD_MHZ(PFD_MHZ), .MODULUS(MODULUS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .freq_i(in_ch.data[27:5]),
    .status_o(status), .exp_o(exp), .nint_o(nint), .frac_o(frac), .mod_o(modv)
  );

  always_comb begin
    unique case (idx)
      3'd0: word = r5_q;
      3'd1: word = 32'h800000 + ({27'd0, exp} << 20) + 32'(200 << 12) + 32'd60;
      3'd2: word = r3_q;
      3'd3: word = r2_q;
      3'd4: word = 32'h8008001 + (modv << 3);
      default: word = (nint << 15) + (frac << 3);
    endcase
  end

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data = {ch_q, word, idx == 3'd5, (idx == 3'd5) ? ~att_q : 5'd0,
                        idx == 3'd5};

endmodule
